FILE: hdl/sacl_pkg.sv
package sacl_pkg;

    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int TAG_W      = 32;

    // widest set field that index_bits can select
    localparam int SEL_W = (1 << CFG_DATA_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = CFG_DATA_W'(0);
    localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST  = CFG_DATA_W'(9);

    typedef enum logic [0:0] {
        OP_ACCESS = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOOK,
        ST_PUSH
    } state_t;

endpackage

FILE: hdl/sacl_req_if.sv
interface sacl_req_if;
    import sacl_pkg::*;

    logic              valid;
    logic              ready;
    op_t               operation;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output operation, output address, input ready);
    modport sink   (input valid, input operation, input address, output ready);
endinterface

FILE: hdl/sacl_rsp_if.sv
interface sacl_rsp_if;
    import sacl_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic             way;
    logic [CNT_W-1:0] miss_count;

    modport source (output valid, output hit, output way, output miss_count, input ready);
    modport sink   (input valid, input hit, input way, input miss_count, output ready);
endinterface

FILE: hdl/sacl_cfg_if.sv
interface sacl_cfg_if;
    import sacl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/set_assoc_cache_lru_lookup_unit.sv
// Tag/valid lookup of a WAYS-way set-associative cache with age-based LRU replacement.
// Each access item splits its byte address into offset, set and tag using the offset_bits
// and index_bits registers (config index 0 and 1, writable any time the block is idle;
// the set field wraps modulo MAX_SETS), checks every way of the set in parallel, fills the
// oldest way on a miss and returns hit, the low bit of the way used and the running miss
// count. A flush item clears all valid bits and returns hit=0, way=0 and the unchanged
// count. Tags with their ages and the valid bits sit in two memories of MAX_SETS rows,
// one row per set, each read through a register in the cycle after the address. An access
// passes through the states IDLE, where it is accepted and the address sliced, DIV for the
// reciprocal multiply of the set modulo, READ for the memory read and LOOK to compare,
// pick the way and write the row back. The result is loaded into the output register in
// LOOK, or from PUSH once it frees; then the next item is taken. A flush sweeps the valid
// memory one row per cycle; its result is loaded from PUSH once the sweep ends and the
// output register is free. After reset the sweep runs over all MAX_SETS rows (valid bits
// cleared, tags zeroed, ages set to the way number) before the first item is accepted.
// Results wait in an output register, so the block accepts the next item while a result
// is still unclaimed; a second result waits inside until that register frees.
module set_assoc_cache_lru_lookup_unit #(
    parameter int WAYS     = 2,
    parameter int MAX_SETS = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    sacl_req_if.sink  req,
    sacl_rsp_if.source rsp,
    sacl_cfg_if.sink  cfg
);
    import sacl_pkg::*;

    // widths that follow from the geometry
    localparam int LOG_SETS = $clog2(MAX_SETS);
    localparam int SETW     = (LOG_SETS > 0) ? LOG_SETS : 1;
    localparam int AW       = (WAYS > 1) ? $clog2(WAYS) : 1;

    // set = s mod MAX_SETS via exact reciprocal: q = (s * RECIP) >> RSH
    localparam int          RSH   = SEL_W + LOG_SETS;
    localparam int          RW    = SEL_W + 2;
    localparam int          PW    = SEL_W + RW;
    localparam int          MW    = SEL_W + LOG_SETS + 1;
    localparam logic [63:0] RECIP = ((64'd1 << RSH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);

    localparam logic [AW-1:0]   AGE_OLDEST = AW'(WAYS - 1);
    localparam logic [SETW-1:0] LAST_SET   = SETW'(MAX_SETS - 1);

    // storage: one row per set, each way keeps its age above its tag
    logic [WAYS-1:0][AW+TAG_W-1:0] line_mem  [MAX_SETS];
    logic [WAYS-1:0]               valid_mem [MAX_SETS];

    logic [WAYS-1:0][AW+TAG_W-1:0] line_rd;
    logic [WAYS-1:0][TAG_W-1:0]    tag_rd;
    logic [WAYS-1:0]               valid_rd;
    logic [WAYS-1:0][AW-1:0]       age_rd;

    // control state
    state_t          state_reg, state_next;
    logic            init_reg, init_next;
    logic [SETW-1:0] sweep_reg, sweep_next;
    logic [CNT_W-1:0] miss_cnt_reg, miss_cnt_next;
    logic [CFG_DATA_W-1:0] offset_bits_reg, offset_bits_next;
    logic [CFG_DATA_W-1:0] index_bits_reg, index_bits_next;
    logic            out_valid_reg, out_valid_next;

    // payload registers
    logic [SEL_W-1:0] sel_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [SEL_W-1:0] quot_reg;
    logic [SETW-1:0]  set_reg;
    logic             res_hit_reg;
    logic             res_way_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic             out_hit_reg;
    logic             out_way_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    // fsm outputs
    logic req_ready;
    logic accept_access;
    logic accept_flush;
    logic div_en;
    logic read_en;
    logic look_en;
    logic clear_en;
    logic out_load;
    logic out_free;

    // address slicing
    logic [ADDR_W-1:0]   addr_shift;
    logic [SEL_W:0]      sel_mask;
    logic [SEL_W-1:0]    sel_calc;
    logic [4:0]          tag_shift;
    logic [TAG_W-1:0]    tag_calc;
    logic [PW-1:0]       recip_prod;
    logic [MW-1:0]       quot_mul;
    logic [MW-1:0]       set_rem;
    logic [SETW-1:0]     set_calc;

    // lookup
    logic [WAYS-1:0]            hit_vec;
    logic [WAYS-1:0]            old_vec;
    logic                       any_hit;
    logic [AW-1:0]              hit_way;
    logic [AW-1:0]              old_way;
    logic [AW-1:0]              found;
    logic [AW-1:0]              own_age;
    logic [WAYS-1:0][TAG_W-1:0] tag_new;
    logic [WAYS-1:0]            valid_new;
    logic [WAYS-1:0][AW-1:0]    age_new;
    logic [WAYS-1:0][AW-1:0]    age_init;

    // memory write side
    logic                          line_we;
    logic                          valid_we;
    logic [SETW-1:0]               mem_waddr;
    logic [WAYS-1:0]               valid_wdata;
    logic [WAYS-1:0][AW+TAG_W-1:0] line_wdata;

    assign out_free = !out_valid_reg || rsp.ready;

    // ---------------------------------------------------------------- config port
    assign cfg.ready = 1'b1;

    always_comb
    begin
        offset_bits_next = offset_bits_reg;
        index_bits_next  = index_bits_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_OFFSET_BITS: offset_bits_next = cfg.data;
                REG_INDEX_BITS:  index_bits_next  = cfg.data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- address slicing
    always_comb
    begin
        addr_shift = req.address >> offset_bits_reg;
        sel_mask   = ((SEL_W+1)'(1) << index_bits_reg) - (SEL_W+1)'(1);
        sel_calc   = addr_shift[SEL_W-1:0] & sel_mask[SEL_W-1:0];
        tag_shift  = {1'b0, offset_bits_reg} + {1'b0, index_bits_reg};
        tag_calc   = req.address >> tag_shift;
    end

    // stage after the quotient: remainder is below MAX_SETS, no correction needed
    assign recip_prod = PW'(sel_reg) * PW'(RECIP[RW-1:0]);
    assign quot_mul   = MW'(quot_reg) * MW'(MAX_SETS);
    assign set_rem    = MW'(sel_reg) - quot_mul;
    assign set_calc   = set_rem[SETW-1:0];

    // ---------------------------------------------------------------- row unpack
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            tag_rd[w] = line_rd[w][TAG_W-1:0];
            age_rd[w] = line_rd[w][AW+TAG_W-1:TAG_W];
        end
    end

    // ---------------------------------------------------------------- way compare
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            hit_vec[w]  = valid_rd[w] && (tag_rd[w] == tag_reg);
            old_vec[w]  = (age_rd[w] == AGE_OLDEST);
            age_init[w] = AW'(w);
        end
        any_hit = |hit_vec;

        // lowest numbered way wins
        hit_way = '0;
        old_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
                hit_way = AW'(w);
            if (old_vec[w])
                old_way = AW'(w);
        end

        found   = any_hit ? hit_way : old_way;
        own_age = age_rd[found];

        for (int w = 0; w < WAYS; w++)
        begin
            if (AW'(w) == found)
            begin
                age_new[w]   = '0;
                valid_new[w] = 1'b1;
                tag_new[w]   = tag_reg;
            end
            else
            begin
                age_new[w]   = (age_rd[w] < own_age) ? age_rd[w] + AW'(1) : age_rd[w];
                valid_new[w] = valid_rd[w];
                tag_new[w]   = tag_rd[w];
            end
        end
    end

    // ---------------------------------------------------------------- fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sweep_reg == LAST_SET)
                    state_next = init_reg ? ST_IDLE : ST_PUSH;
            end
            ST_IDLE:
            begin
                if (req.valid)
                    state_next = (req.operation == OP_FLUSH) ? ST_CLEAR : ST_DIV;
            end
            ST_DIV:  state_next = ST_READ;
            ST_READ: state_next = ST_LOOK;
            ST_LOOK: state_next = out_free ? ST_IDLE : ST_PUSH;
            ST_PUSH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- fsm outputs
    always_comb
    begin
        req_ready = 1'b0;
        div_en    = 1'b0;
        read_en   = 1'b0;
        look_en   = 1'b0;
        clear_en  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clear_en  = 1'b1;
            ST_IDLE:  req_ready = 1'b1;
            ST_DIV:   div_en    = 1'b1;
            ST_READ:  read_en   = 1'b1;
            ST_LOOK:
            begin
                look_en  = 1'b1;
                out_load = out_free;
            end
            ST_PUSH:  out_load  = out_free;
            default:  ;
        endcase
    end

    assign req.ready     = req_ready;
    assign accept_access = req.valid && req_ready && (req.operation == OP_ACCESS);
    assign accept_flush  = req.valid && req_ready && (req.operation == OP_FLUSH);

    // ---------------------------------------------------------------- next values
    always_comb
    begin
        init_next     = init_reg;
        sweep_next    = sweep_reg;
        miss_cnt_next = miss_cnt_reg;

        if (accept_flush)
        begin
            init_next  = 1'b0;
            sweep_next = '0;
        end
        if (clear_en)
            sweep_next = sweep_reg + SETW'(1);
        if (look_en && !any_hit)
            miss_cnt_next = miss_cnt_reg + CNT_W'(1);

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // memory write side: sweep or write-back of the looked-up row
    always_comb
    begin
        line_we     = look_en || (clear_en && init_reg);
        valid_we    = look_en || clear_en;
        mem_waddr   = clear_en ? sweep_reg : set_reg;
        valid_wdata = clear_en ? '0 : valid_new;
        for (int w = 0; w < WAYS; w++)
            line_wdata[w] = clear_en ? {age_init[w], TAG_W'(0)} : {age_new[w], tag_new[w]};
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            init_reg        <= 1'b1;
            sweep_reg       <= '0;
            miss_cnt_reg    <= '0;
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_reg        <= init_next;
            sweep_reg       <= sweep_next;
            miss_cnt_reg    <= miss_cnt_next;
            offset_bits_reg <= offset_bits_next;
            index_bits_reg  <= index_bits_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_access)
        begin
            sel_reg <= sel_calc;
            tag_reg <= tag_calc;
        end
        if (div_en)
            quot_reg <= SEL_W'(recip_prod >> RSH);
        if (read_en)
            set_reg <= set_calc;

        if (accept_flush)
        begin
            res_hit_reg <= 1'b0;
            res_way_reg <= 1'b0;
            res_cnt_reg <= miss_cnt_reg;
        end
        else if (look_en)
        begin
            res_hit_reg <= any_hit;
            res_way_reg <= found[0];
            res_cnt_reg <= miss_cnt_next;
        end

        if (out_load)
        begin
            if (look_en)
            begin
                out_hit_reg <= any_hit;
                out_way_reg <= found[0];
                out_cnt_reg <= miss_cnt_next;
            end
            else
            begin
                out_hit_reg <= res_hit_reg;
                out_way_reg <= res_way_reg;
                out_cnt_reg <= res_cnt_reg;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way        = out_way_reg;
    assign rsp.miss_count = out_cnt_reg;

    // ---------------------------------------------------------------- memories
    always_ff @(posedge clk)
    begin
        if (line_we)
            line_mem[mem_waddr] <= line_wdata;
        line_rd <= line_mem[set_calc];
    end

    always_ff @(posedge clk)
    begin
        if (valid_we)
            valid_mem[mem_waddr] <= valid_wdata;
        valid_rd <= valid_mem[set_calc];
    end

    // ---------------------------------------------------------------- assertions
    // ages of a set stay a permutation, so exactly one way is the oldest
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        look_en |-> $onehot(old_vec))
        else $error("set without a unique oldest way");

    // an accepted access reaches the compare stage after a fixed latency
    a_access_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept_access |-> ##3 (state_reg == ST_LOOK))
        else $error("access did not reach lookup on time");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || rsp.ready))
        else $error("output register overwritten");

    // the miss counter steps by one exactly on a lookup miss
    a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
        (look_en && !any_hit) |=> (miss_cnt_reg == $past(miss_cnt_reg) + CNT_W'(1)))
        else $error("miss counter did not advance");

    // no item is taken while the valid sweep runs
    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clear_en |-> !req.ready)
        else $error("item accepted during sweep");

endmodule
